// ===== sv/sir_pkg.sv =====
package sir_pkg;

    localparam int SW_BITS          = 5;
    localparam int TIME_IN_BITS     = 32;
    localparam int S_TDATA_BITS     = 72;
    localparam int S_TUSER_BITS     = 2;
    localparam int M_TDATA_BITS     = 8;

    localparam int NUM_SWITCHES_DEF = 22;
    localparam int NUM_SLOTS_DEF    = 32;
    localparam int TIME_BITS_DEF    = 32;

    // set bit means the switch comes out of reset straight
    localparam logic [31:0] STRAIGHT_AT_RESET = 32'h0028_05C8;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_READ    = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERLAP  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_MISMATCH = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } t_state;

    // running search flags handed from cell to cell
    typedef struct packed {
        logic conflict;
        logic any;
        logic free_found;
        logic best_found;
    } t_carry;

endpackage

// ===== sv/sir_cell.sv =====
module sir_cell
    import sir_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int SLOT_BITS = 5,
    parameter int CELL_IDX  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SW_BITS-1:0]   i_sw,
    input  logic [TIME_BITS-1:0] i_start,
    input  logic [TIME_BITS-1:0] i_end,
    input  logic                 i_dir,
    input  logic                 i_wr,
    input  logic                 i_clr,
    input  logic [SLOT_BITS-1:0] i_sel_idx,
    input  t_carry               i_carry,
    input  logic [SLOT_BITS-1:0] i_free_idx,
    input  logic [SLOT_BITS-1:0] i_best_idx,
    input  logic [TIME_BITS-1:0] i_best_start,
    input  logic                 i_best_dir,
    output t_carry               o_carry,
    output logic [SLOT_BITS-1:0] o_free_idx,
    output logic [SLOT_BITS-1:0] o_best_idx,
    output logic [TIME_BITS-1:0] o_best_start,
    output logic                 o_best_dir,
    output logic                 o_valid
);

    localparam logic [SLOT_BITS-1:0] MY_IDX = SLOT_BITS'(CELL_IDX);

    logic                 r_valid;
    logic [SW_BITS-1:0]   r_sw;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_end;
    logic                 r_dir;

    t_carry               r_carry;
    t_carry               n_carry;
    logic [SLOT_BITS-1:0] r_free_idx;
    logic [SLOT_BITS-1:0] n_free_idx;
    logic [SLOT_BITS-1:0] r_best_idx;
    logic [SLOT_BITS-1:0] n_best_idx;
    logic [TIME_BITS-1:0] r_best_start;
    logic [TIME_BITS-1:0] n_best_start;
    logic                 r_best_dir;
    logic                 n_best_dir;

    logic                 c_sel;
    logic                 c_match;
    logic                 c_overlap;

    assign c_sel = (i_sel_idx == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr && c_sel) begin
            r_valid <= 1'b1;
        end else if (i_clr && c_sel) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && c_sel) begin
            r_sw    <= i_sw;
            r_start <= i_start;
            r_end   <= i_end;
            r_dir   <= i_dir;
        end
    end

    assign c_match   = r_valid && (r_sw == i_sw);
    // second term covers intervals that wrap (end before start)
    assign c_overlap = ((r_start <= i_end) && (r_end >= i_start)) ||
                       ((r_end <= i_start) && (r_start >= i_end));

    always_comb begin
        n_carry      = i_carry;
        n_free_idx   = i_free_idx;
        n_best_idx   = i_best_idx;
        n_best_start = i_best_start;
        n_best_dir   = i_best_dir;
        if (c_match) begin
            n_carry.any = 1'b1;
            if (c_overlap) begin
                n_carry.conflict = 1'b1;
            end
            if (!i_carry.best_found || (r_start < i_best_start)) begin
                n_carry.best_found = 1'b1;
                n_best_idx         = MY_IDX;
                n_best_start       = r_start;
                n_best_dir         = r_dir;
            end
        end
        if (!r_valid && !i_carry.free_found) begin
            n_carry.free_found = 1'b1;
            n_free_idx         = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx   <= n_free_idx;
        r_best_idx   <= n_best_idx;
        r_best_start <= n_best_start;
        r_best_dir   <= n_best_dir;
    end

    assign o_carry      = r_carry;
    assign o_free_idx   = r_free_idx;
    assign o_best_idx   = r_best_idx;
    assign o_best_start = r_best_start;
    assign o_best_dir   = r_best_dir;
    assign o_valid      = r_valid;

endmodule

// ===== sv/switch_interval_reservation.sv =====
// an input transfer starts a search through the chain of interval cells; the
// result goes to the output register once the search has rippled
// one slot cell per cycle down the chain, and only then is a new item accepted
// a waiting result sits in the output register while the next item is searched
// reset (synchronous, active low) empties every slot and restores the default
// switch directions; no clearing pass is needed
module switch_interval_reservation
    import sir_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF,
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // switch_index[4:0], start_time[36:5], end_time[68:37], want_direction[69]
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_BITS-1:0] s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // status[2:0], direction_out[3], set_now[4]
    output logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
    localparam int SW_IDX_BITS = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
    localparam logic [SLOT_BITS-1:0] LAST_CNT = SLOT_BITS'(NUM_SLOTS - 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [SLOT_BITS-1:0]    r_cnt;

    t_req                    r_req;
    logic [SW_BITS-1:0]      r_sw;
    logic [TIME_BITS-1:0]    r_start;
    logic [TIME_BITS-1:0]    r_end;
    logic                    r_dir;

    logic [NUM_SWITCHES-1:0] r_pos;

    logic                    r_out_valid;
    logic [M_TDATA_BITS-1:0] r_out_data;

    t_carry                  w_carry      [NUM_SLOTS+1];
    logic [SLOT_BITS-1:0]    w_free_idx   [NUM_SLOTS+1];
    logic [SLOT_BITS-1:0]    w_best_idx   [NUM_SLOTS+1];
    logic [TIME_BITS-1:0]    w_best_start [NUM_SLOTS+1];
    logic                    w_best_dir   [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0]    w_valid;

    logic                    c_in_xfer;
    logic                    c_out_free;
    logic                    c_fire;
    logic                    c_wr;
    logic                    c_clr;
    logic [SLOT_BITS-1:0]    c_sel_idx;
    logic                    c_pos_we;
    logic                    c_pos_val;
    logic                    c_in_range;
    logic                    c_pos_cur;
    t_status                 c_status;
    logic                    c_dir_out;
    logic                    c_set_now;
    t_carry                  c_last;

    assign c_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign c_out_free = !r_out_valid || m_axis_tready;
    assign c_last     = w_carry[NUM_SLOTS];

    // request capture
    always_ff @(posedge i_clk) begin
        if (c_in_xfer) begin
            r_req   <= t_req'(s_axis_tuser);
            r_sw    <= s_axis_tdata[SW_BITS-1:0];
            r_start <= TIME_BITS'(s_axis_tdata[SW_BITS +: TIME_IN_BITS]);
            r_end   <= TIME_BITS'(s_axis_tdata[SW_BITS+TIME_IN_BITS +: TIME_IN_BITS]);
            r_dir   <= s_axis_tdata[SW_BITS+2*TIME_IN_BITS];
        end
    end

    // slot chain
    assign w_carry[0]      = '0;
    assign w_free_idx[0]   = '0;
    assign w_best_idx[0]   = '0;
    assign w_best_start[0] = '0;
    assign w_best_dir[0]   = 1'b0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        sir_cell #(
            .TIME_BITS (TIME_BITS),
            .SLOT_BITS (SLOT_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_sw         (r_sw),
            .i_start      (r_start),
            .i_end        (r_end),
            .i_dir        (r_dir),
            .i_wr         (c_wr),
            .i_clr        (c_clr),
            .i_sel_idx    (c_sel_idx),
            .i_carry      (w_carry[g]),
            .i_free_idx   (w_free_idx[g]),
            .i_best_idx   (w_best_idx[g]),
            .i_best_start (w_best_start[g]),
            .i_best_dir   (w_best_dir[g]),
            .o_carry      (w_carry[g+1]),
            .o_free_idx   (w_free_idx[g+1]),
            .o_best_idx   (w_best_idx[g+1]),
            .o_best_start (w_best_start[g+1]),
            .o_best_dir   (w_best_dir[g+1]),
            .o_valid      (w_valid[g])
        );
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == FSM_SCAN) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (c_in_xfer) begin
                    n_state = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (r_cnt == LAST_CNT) begin
                    n_state = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (c_out_free) begin
                    n_state = FSM_IDLE;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

    // decision from the end of the chain
    assign c_in_range = ({1'b0, r_sw} < (SW_BITS + 1)'(NUM_SWITCHES));
    assign c_pos_cur  = c_in_range ? r_pos[r_sw[SW_IDX_BITS-1:0]] : 1'b0;

    always_comb begin
        s_axis_tready = 1'b0;
        c_fire        = 1'b0;
        c_wr          = 1'b0;
        c_clr         = 1'b0;
        c_sel_idx     = w_free_idx[NUM_SLOTS];
        c_pos_we      = 1'b0;
        c_pos_val     = r_dir;
        c_status      = ST_OK;
        c_set_now     = 1'b0;
        case (r_state)
            FSM_IDLE: s_axis_tready = 1'b1;
            FSM_DONE: c_fire = c_out_free;
            default: ;
        endcase
        if (!c_in_range) begin
            case (r_req)
                REQ_ALLOC:   c_status = ST_FULL;
                REQ_RELEASE: c_status = ST_EMPTY;
                default:     c_status = ST_OK;
            endcase
        end else begin
            case (r_req)
                REQ_ALLOC: begin
                    if (c_last.conflict) begin
                        c_status = ST_OVERLAP;
                    end else if (!c_last.free_found) begin
                        c_status = ST_FULL;
                    end else begin
                        c_wr = c_fire;
                        if (!c_last.any) begin
                            c_pos_we  = c_fire;
                            c_set_now = 1'b1;
                        end
                    end
                end
                REQ_RELEASE: begin
                    c_sel_idx = w_best_idx[NUM_SLOTS];
                    c_pos_val = w_best_dir[NUM_SLOTS];
                    if (!c_last.best_found) begin
                        c_status = ST_EMPTY;
                    end else if (w_best_start[NUM_SLOTS] != r_start) begin
                        c_status = ST_MISMATCH;
                    end else begin
                        c_clr     = c_fire;
                        c_pos_we  = c_fire;
                        c_set_now = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        c_dir_out = c_set_now ? c_pos_val : c_pos_cur;
    end

    // switch directions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ~STRAIGHT_AT_RESET[NUM_SWITCHES-1:0];
        end else if (c_pos_we) begin
            r_pos[r_sw[SW_IDX_BITS-1:0]] <= c_pos_val;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire) begin
            r_out_data <= {3'b000, c_set_now, c_dir_out, c_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_set_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[4] |-> r_out_data[2:0] == ST_OK)
        else $error("direction change reported with an error status");

    a_wr_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(c_wr && c_clr))
        else $error("slot written and cleared in the same transfer");

    a_slots_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !c_wr && !c_clr |=> $stable(w_valid))
        else $error("slot occupancy changed without a commit");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_in_xfer |=> r_state == FSM_SCAN && r_cnt == '0)
        else $error("search did not start after input transfer");

    a_commit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_fire |=> !c_fire && r_out_valid)
        else $error("result committed twice or lost");

endmodule
